// ----- sv/plsm_pkg.sv -----
// ----------------------------------------------------------------------------
// plsm_pkg
// Shared types and fixed widths of the piecewise-linear secant modulus block.
// ----------------------------------------------------------------------------
package plsm_pkg;

    localparam int BP_W     = 31;   // breakpoint strain, unsigned Q1.30
    localparam int MOD_W    = 48;   // modulus, 8 fractional bits
    localparam int STRAIN_W = 32;   // query strain, signed Q1.30
    localparam int MAG_A_W  = 32;   // strain magnitude, up to 2^31
    localparam int SEG_W    = 5;
    localparam int IN_IDX_W = 4;
    localparam int D_W      = 33;   // strain difference, signed
    localparam int HALF_W   = 24;   // modulus split for the multiplier
    localparam int PROD_W   = D_W + HALF_W + 1;
    localparam int Q_W      = 48;   // quotient bits kept

    localparam logic [SEG_W-1:0] SEG_RESET = 5'd1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [Q_W-1:0] LIMIT_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [Q_W-1:0] LIMIT_NEG = 48'h8000_0000_0000;

    typedef struct packed {
        logic [BP_W-1:0]  bp;
        logic [MOD_W-1:0] modulus;
    } entry_t;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [Q_W-1:0]   value;
    } div_res_t;

endpackage

// ----- sv/piecewise_linear_secant_modulus.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_secant_modulus
// Secant modulus of a multilinear elastic law held in a breakpoint table.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. kind selects a load
// (writes entry entry_index with breakpoint_strain and segment_modulus) or a
// query (uses the magnitude of strain). A load takes the accept cycle only
// and busy stays low. A query raises busy until its result is ready; the
// result then shows on secant_modulus and saturated for one cycle with done
// high, and busy is already low in that cycle. The receiver cannot stall.
// Query time depends on n, the segment count in use (0 counts as 1, capped at
// the depth), and on c, the chosen entry. A zero strain skips the walk and the
// divider, and a quotient that overflows 48 bits skips the divider loop. The
// table search reads one entry a cycle from a memory with one read port; the
// walk takes two passes of a shared 33x25 multiplier per segment, and the
// divider yields one quotient bit per cycle over 48 bits.
// segments_in_use is written with segments_in_use_we, only while idle; the user
// must keep to that, as the block itself does not enforce it. Reset returns the
// segment count to 1; table entries are undefined until loaded and no clearing pass runs.
// ----------------------------------------------------------------------------
module piecewise_linear_secant_modulus #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 kind,
    input  logic [plsm_pkg::IN_IDX_W-1:0]        entry_index,
    input  logic [plsm_pkg::BP_W-1:0]            breakpoint_strain,
    input  logic signed [plsm_pkg::MOD_W-1:0]    segment_modulus,
    input  logic signed [plsm_pkg::STRAIN_W-1:0] strain,
    input  logic                                 segments_in_use_we,
    input  logic [plsm_pkg::SEG_W-1:0]           segments_in_use,
    output logic                                 done,
    output logic signed [plsm_pkg::MOD_W-1:0]    secant_modulus,
    output logic                                 saturated
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int ACC_W = 80 + IDX_W;
    localparam int MAG_W = ACC_W - 1;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SEARCH   = 11'b000_0000_0010,
        S_ACC_RD   = 11'b000_0000_0100,
        S_ACC_LAT  = 11'b000_0000_1000,
        S_MUL_LO   = 11'b000_0001_0000,
        S_MUL_HI   = 11'b000_0010_0000,
        S_MUL_ADD  = 11'b000_0100_0000,
        S_MAG      = 11'b000_1000_0000,
        S_DIV      = 11'b001_0000_0000,
        S_ZERO_RD  = 11'b010_0000_0000,
        S_ZERO_OUT = 11'b100_0000_0000
    } state_t;

    state_t                                state_reg, state_next;
    logic [plsm_pkg::SEG_W-1:0]            seg_reg, seg_next;
    logic                                  iss_reg, iss_next;
    logic                                  chk_valid_reg, chk_valid_next;
    logic                                  div_go_reg, div_go_next;
    logic                                  done_reg, done_next;

    logic [plsm_pkg::MAG_A_W-1:0]          a_reg, a_next;
    logic [IDX_W-1:0]                      srch_addr_reg, srch_addr_next;
    logic [IDX_W-1:0]                      chk_addr_reg, chk_addr_next;
    logic [IDX_W-1:0]                      chosen_reg, chosen_next;
    logic [IDX_W-1:0]                      k_reg, k_next;
    logic                                  last_reg, last_next;
    logic [plsm_pkg::BP_W-1:0]             prev_bp_reg, prev_bp_next;
    logic [plsm_pkg::MOD_W-1:0]            prev_mod_reg, prev_mod_next;
    logic [plsm_pkg::BP_W-1:0]             nxt_bp_reg, nxt_bp_next;
    logic [plsm_pkg::MOD_W-1:0]            nxt_mod_reg, nxt_mod_next;
    logic signed [plsm_pkg::D_W-1:0]       d_reg, d_next;
    logic signed [plsm_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic signed [ACC_W-1:0]               acc_reg, acc_next;
    logic [MAG_W-1:0]                      mag_reg, mag_next;
    logic                                  neg_reg, neg_next;
    logic [plsm_pkg::MOD_W-1:0]            secant_reg, secant_next;
    logic                                  sat_reg, sat_next;

    logic                                  wr_en;
    logic [IDX_W-1:0]                      rd_addr;
    plsm_pkg::entry_t                      wr_data;
    plsm_pkg::entry_t                      rd_data;
    plsm_pkg::div_res_t                    div_res;

    logic [plsm_pkg::MAG_A_W-1:0]          a_in;
    logic                                  in_range;
    logic [IDX_W-1:0]                      top_idx;
    logic signed [plsm_pkg::HALF_W:0]      mul_b;
    logic signed [plsm_pkg::PROD_W-1:0]    prod;
    logic signed [ACC_W-1:0]               acc_abs;

    // magnitude; the most negative strain maps to 2^31 exactly
    assign a_in = strain[plsm_pkg::STRAIN_W-1] ? plsm_pkg::MAG_A_W'(-strain)
                                               : plsm_pkg::MAG_A_W'(strain);

    assign in_range = 32'(entry_index) < TABLE_DEPTH;

    // highest entry taking part in the search
    always_comb
    begin
        if (seg_reg == '0)
        begin
            top_idx = '0;
        end
        else if (32'(seg_reg) >= TABLE_DEPTH)
        begin
            top_idx = IDX_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            top_idx = IDX_W'(seg_reg - 1'b1);
        end
    end

    // shared multiplier: low half of the modulus first, then the signed high half
    assign mul_b = (state_reg == S_MUL_HI)
                 ? $signed({prev_mod_reg[plsm_pkg::MOD_W-1],
                            prev_mod_reg[plsm_pkg::MOD_W-1:plsm_pkg::HALF_W]})
                 : $signed({1'b0, prev_mod_reg[plsm_pkg::HALF_W-1:0]});
    assign prod  = d_reg * mul_b;

    assign acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;

    assign wr_data.bp      = breakpoint_strain;
    assign wr_data.modulus = segment_modulus;

    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        iss_next       = iss_reg;
        chk_valid_next = chk_valid_reg;
        div_go_next    = 1'b0;
        done_next      = 1'b0;
        a_next         = a_reg;
        srch_addr_next = srch_addr_reg;
        chk_addr_next  = chk_addr_reg;
        chosen_next    = chosen_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        prev_bp_next   = prev_bp_reg;
        prev_mod_next  = prev_mod_reg;
        nxt_bp_next    = nxt_bp_reg;
        nxt_mod_next   = nxt_mod_reg;
        d_next         = d_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        secant_next    = secant_reg;
        sat_next       = sat_reg;
        wr_en          = 1'b0;
        rd_addr        = k_reg;

        if (segments_in_use_we)
        begin
            seg_next = segments_in_use;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (kind == plsm_pkg::KIND_LOAD)
                    begin
                        wr_en = in_range;
                    end
                    else
                    begin
                        a_next   = a_in;
                        acc_next = '0;
                        if (a_in == '0)
                        begin
                            state_next = S_ZERO_RD;
                        end
                        else
                        begin
                            srch_addr_next = top_idx;
                            iss_next       = 1'b1;
                            chk_valid_next = 1'b0;
                            state_next     = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                // read one entry a cycle going down, test it in the next cycle
                rd_addr        = srch_addr_reg;
                chk_valid_next = iss_reg;
                chk_addr_next  = srch_addr_reg;
                if (iss_reg)
                begin
                    if (srch_addr_reg == '0)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        srch_addr_next = srch_addr_reg - 1'b1;
                    end
                end
                if (chk_valid_reg &&
                    (({1'b0, rd_data.bp} <= a_reg) || (chk_addr_reg == '0)))
                begin
                    chosen_next = chk_addr_reg;
                    k_next      = '0;
                    last_next   = 1'b0;
                    iss_next    = 1'b0;
                    state_next  = S_ACC_RD;
                end
            end
            S_ACC_RD:
            begin
                rd_addr    = k_reg;
                state_next = S_ACC_LAT;
            end
            S_ACC_LAT:
            begin
                if (k_reg == '0)
                begin
                    prev_bp_next  = rd_data.bp;
                    prev_mod_next = rd_data.modulus;
                    if (chosen_reg == '0)
                    begin
                        d_next     = $signed({1'b0, a_reg} - {2'b00, rd_data.bp});
                        last_next  = 1'b1;
                        state_next = S_MUL_LO;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_ACC_RD;
                    end
                end
                else
                begin
                    // full segment between the previous breakpoint and this one
                    d_next       = $signed({2'b00, rd_data.bp} - {2'b00, prev_bp_reg});
                    nxt_bp_next  = rd_data.bp;
                    nxt_mod_next = rd_data.modulus;
                    state_next   = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                prod_next  = prod;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                prod_next  = prod;
                state_next = S_MUL_ADD;
            end
            S_MUL_ADD:
            begin
                acc_next = acc_reg + (ACC_W'(prod_reg) <<< plsm_pkg::HALF_W);
                if (last_reg)
                begin
                    state_next = S_MAG;
                end
                else
                begin
                    prev_bp_next  = nxt_bp_reg;
                    prev_mod_next = nxt_mod_reg;
                    if (k_reg == chosen_reg)
                    begin
                        // partial segment up to the strain itself
                        d_next     = $signed({1'b0, a_reg} - {2'b00, nxt_bp_reg});
                        last_next  = 1'b1;
                        state_next = S_MUL_LO;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_ACC_RD;
                    end
                end
            end
            S_MAG:
            begin
                neg_next    = acc_reg[ACC_W-1];
                mag_next    = acc_abs[MAG_W-1:0];
                div_go_next = 1'b1;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    done_next   = 1'b1;
                    secant_next = div_res.value;
                    sat_next    = div_res.sat;
                    state_next  = S_IDLE;
                end
            end
            S_ZERO_RD:
            begin
                rd_addr    = '0;
                state_next = S_ZERO_OUT;
            end
            S_ZERO_OUT:
            begin
                done_next   = 1'b1;
                secant_next = rd_data.modulus;
                sat_next    = 1'b0;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_reg       <= plsm_pkg::SEG_RESET;
            iss_reg       <= 1'b0;
            chk_valid_reg <= 1'b0;
            div_go_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            iss_reg       <= iss_next;
            chk_valid_reg <= chk_valid_next;
            div_go_reg    <= div_go_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        srch_addr_reg <= srch_addr_next;
        chk_addr_reg  <= chk_addr_next;
        chosen_reg    <= chosen_next;
        k_reg         <= k_next;
        last_reg      <= last_next;
        prev_bp_reg   <= prev_bp_next;
        prev_mod_reg  <= prev_mod_next;
        nxt_bp_reg    <= nxt_bp_next;
        nxt_mod_reg   <= nxt_mod_next;
        d_reg         <= d_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        secant_reg    <= secant_next;
        sat_reg       <= sat_next;
    end

    // loads land only while idle and a query reads only after its accept, so no forwarding
    plsm_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (IDX_W'(entry_index)),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    plsm_div #(
        .MAG_W (MAG_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go_reg),
        .mag     (mag_reg),
        .divisor (a_reg),
        .neg     (neg_reg),
        .res     (div_res)
    );

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign secant_modulus = secant_reg;
    assign saturated      = sat_reg;

endmodule

// ----- sv/plsm_table.sv -----
// ----------------------------------------------------------------------------
// plsm_table
// Breakpoint and modulus table: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module plsm_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
    input  plsm_pkg::entry_t               wdata,
    input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
    output plsm_pkg::entry_t               rdata
);

    plsm_pkg::entry_t mem [TABLE_DEPTH];
    plsm_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/plsm_div.sv -----
// ----------------------------------------------------------------------------
// plsm_div
// Restoring divider, one quotient bit per cycle, with range check and sign.
// ----------------------------------------------------------------------------
module plsm_div #(
    parameter int MAG_W = 83
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [MAG_W-1:0]             mag,
    input  logic [plsm_pkg::MAG_A_W-1:0] divisor,
    input  logic                         neg,
    output plsm_pkg::div_res_t           res
);

    localparam int HI_W  = MAG_W - plsm_pkg::Q_W;
    localparam int CNT_W = $clog2(plsm_pkg::Q_W);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIN  = 3'b100
    } dstate_t;

    dstate_t                          st_reg, st_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             done_reg, done_next;
    logic [plsm_pkg::MAG_A_W-1:0]     rem_reg, rem_next;
    logic [plsm_pkg::Q_W-1:0]         q_reg, q_next;
    logic                             neg_reg, neg_next;
    logic                             sat_reg, sat_next;
    logic [plsm_pkg::Q_W-1:0]         value_reg, value_next;

    logic [HI_W-1:0]                  hi;
    logic                             ovf;
    logic [plsm_pkg::MAG_A_W+1:0]     diff;
    logic                             ge;
    logic [plsm_pkg::Q_W-1:0]         limit;
    logic                             over;
    logic [plsm_pkg::Q_W-1:0]         clipped;

    // quotient needs more than 48 bits exactly when the top part reaches the divisor
    assign hi  = mag[MAG_W-1:plsm_pkg::Q_W];
    assign ovf = hi >= HI_W'(divisor);

    assign diff = {1'b0, rem_reg, q_reg[plsm_pkg::Q_W-1]} - {2'b00, divisor};
    assign ge   = !diff[plsm_pkg::MAG_A_W+1];

    assign limit   = neg_reg ? plsm_pkg::LIMIT_NEG : plsm_pkg::LIMIT_POS;
    assign over    = q_reg > limit;
    assign clipped = over ? limit : q_reg;

    always_comb
    begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        q_next     = q_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        value_next = value_reg;
        case (st_reg)
            D_IDLE:
            begin
                if (go)
                begin
                    neg_next = neg;
                    if (ovf)
                    begin
                        done_next  = 1'b1;
                        sat_next   = 1'b1;
                        value_next = neg ? plsm_pkg::LIMIT_NEG : plsm_pkg::LIMIT_POS;
                    end
                    else
                    begin
                        rem_next = hi[plsm_pkg::MAG_A_W-1:0];
                        q_next   = mag[plsm_pkg::Q_W-1:0];
                        cnt_next = CNT_W'(plsm_pkg::Q_W - 1);
                        st_next  = D_RUN;
                    end
                end
            end
            D_RUN:
            begin
                rem_next = ge ? diff[plsm_pkg::MAG_A_W-1:0]
                              : {rem_reg[plsm_pkg::MAG_A_W-2:0], q_reg[plsm_pkg::Q_W-1]};
                q_next   = {q_reg[plsm_pkg::Q_W-2:0], ge};
                if (cnt_reg == '0)
                begin
                    st_next = D_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            D_FIN:
            begin
                done_next  = 1'b1;
                sat_next   = over;
                value_next = neg_reg ? (plsm_pkg::Q_W'(0) - clipped) : clipped;
                st_next    = D_IDLE;
            end
            default:
            begin
                st_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= D_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        neg_reg   <= neg_next;
        sat_reg   <= sat_next;
        value_reg <= value_next;
    end

    assign res.done  = done_reg;
    assign res.sat   = sat_reg;
    assign res.value = value_reg;

endmodule

// ----- sv/plsm_checker.sv -----
// ----------------------------------------------------------------------------
// plsm_checker
// Port-level checks of the secant modulus block, bound to the top level.
// ----------------------------------------------------------------------------
module plsm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              kind,
    input logic                              done,
    input logic signed [plsm_pkg::MOD_W-1:0] secant_modulus,
    input logic                              saturated
);

    // a load beat completes in its accept cycle
    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == plsm_pkg::KIND_LOAD) |=> !busy)
        else $error("load left the block busy");

    // a query beat always occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == plsm_pkg::KIND_QUERY) |=> busy)
        else $error("query did not raise busy");

    // the result beat follows a busy period and finds the block free
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result beat outside a query");

    // a clipped result sits on one of the two range limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
            (secant_modulus == plsm_pkg::LIMIT_POS || secant_modulus == plsm_pkg::LIMIT_NEG))
        else $error("saturated result not at a limit");

endmodule

bind piecewise_linear_secant_modulus plsm_checker u_plsm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .done           (done),
    .secant_modulus (secant_modulus),
    .saturated      (saturated)
);

// ----- verif/tb_piecewise_linear_secant_modulus.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_secant_modulus
// Self-checking bench for the multilinear secant modulus block. A local copy
// of the breakpoint and modulus tables predicts every query, and each done
// beat is checked in order against that prediction. The run covers directed
// corners, segment-count sweeps and random well-formed and broken traffic.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_secant_modulus;

    localparam int TABLE_DEPTH     = 16;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int LOAD_SETTLE     = 4;
    localparam int QUERY_LATENCY   = 200;
    localparam int IDLE_LIMIT      = 3000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        logic signed [plsm_pkg::MOD_W-1:0] modulus;
        logic                              sat_flag;
    } secant_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic                                 kind;
    logic [plsm_pkg::IN_IDX_W-1:0]        entry_index;
    logic [plsm_pkg::BP_W-1:0]            breakpoint_strain;
    logic signed [plsm_pkg::MOD_W-1:0]    segment_modulus;
    logic signed [plsm_pkg::STRAIN_W-1:0] strain;
    logic                                 segments_in_use_we;
    logic [plsm_pkg::SEG_W-1:0]           segments_in_use;
    logic                                 done;
    logic signed [plsm_pkg::MOD_W-1:0]    secant_modulus;
    logic                                 saturated;

    // predictor state
    logic [plsm_pkg::BP_W-1:0]         bp_tab [TABLE_DEPTH];
    logic signed [plsm_pkg::MOD_W-1:0] modulus_tab [TABLE_DEPTH];
    logic [plsm_pkg::SEG_W-1:0]        seg_count;

    secant_t pending_secants[$];

    int mismatches       = 0;
    int loads_sent       = 0;
    int queries_sent     = 0;
    int results_checked  = 0;
    int saturations_seen = 0;
    int settings_used    = 0;

    piecewise_linear_secant_modulus #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .kind               (kind),
        .entry_index        (entry_index),
        .breakpoint_strain  (breakpoint_strain),
        .segment_modulus    (segment_modulus),
        .strain             (strain),
        .segments_in_use_we (segments_in_use_we),
        .segments_in_use    (segments_in_use),
        .done               (done),
        .secant_modulus     (secant_modulus),
        .saturated          (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stress integral over the walked segments, divided by the strain magnitude
    function automatic secant_t predict_secant(logic [plsm_pkg::STRAIN_W-1:0] strain_in);
        logic [plsm_pkg::MAG_A_W-1:0] mag;
        int                           n;
        int                           chosen;
        logic signed [127:0]          stress;
        logic signed [127:0]          wm;
        logic signed [127:0]          wd;
        logic [127:0]                 absval;
        logic [127:0]                 quot;
        logic [127:0]                 limit;
        logic                         neg;
        secant_t                      r;
        mag = strain_in[plsm_pkg::STRAIN_W-1] ? (~strain_in + 32'd1) : strain_in;
        if (mag == '0)
        begin
            r.modulus  = modulus_tab[0];
            r.sat_flag = 1'b0;
            return r;
        end
        n = (seg_count == '0) ? 1 : ((seg_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(seg_count));
        chosen = 0;
        for (int i = 0; i < n; i++)
        begin
            if (mag >= {1'b0, bp_tab[i]})
                chosen = i;
        end
        stress = '0;
        for (int k = 0; k < chosen; k++)
        begin
            wm = modulus_tab[k];
            wd = $signed({2'b00, bp_tab[k+1]}) - $signed({2'b00, bp_tab[k]});
            stress = stress + wm * wd;
        end
        wm = modulus_tab[chosen];
        wd = $signed({1'b0, mag}) - $signed({2'b00, bp_tab[chosen]});
        stress = stress + wm * wd;
        neg    = stress[127];
        absval = neg ? -stress : stress;
        quot   = absval / {96'd0, mag};
        limit  = neg ? {80'd0, plsm_pkg::LIMIT_NEG} : {80'd0, plsm_pkg::LIMIT_POS};
        if (quot > limit)
        begin
            quot       = limit;
            r.sat_flag = 1'b1;
        end
        else
            r.sat_flag = 1'b0;
        r.modulus = neg ? -quot[plsm_pkg::MOD_W-1:0] : quot[plsm_pkg::MOD_W-1:0];
        return r;
    endfunction

    function automatic int next_gap(bit back_to_back);
        int roll;
        if (back_to_back)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic signed [plsm_pkg::MOD_W-1:0] pick_modulus();
        logic [63:0] raw;
        int          sel;
        raw = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return raw[plsm_pkg::MOD_W-1:0];
        if (sel == 1)
            return raw[0] ? plsm_pkg::LIMIT_POS : plsm_pkg::LIMIT_NEG;
        return plsm_pkg::MOD_W'($signed(raw[40:0]));
    endfunction

    function automatic logic [plsm_pkg::STRAIN_W-1:0] pick_strain();
        longint unsigned mag;
        longint unsigned bound;
        int              sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0: mag = 0;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3, 4, 5:
            begin
                // right on a breakpoint or just short of it
                mag = 64'(bp_tab[$urandom_range(0, TABLE_DEPTH-1)]);
                if ($urandom_range(0, 1) && mag > 0)
                    mag = mag - 1;
            end
            6: return $urandom;
            default:
            begin
                bound = bp_tab[TABLE_DEPTH-1] + bp_tab[TABLE_DEPTH-1] / 4 + 16;
                if (bound > 64'h8000_0000)
                    bound = 64'h8000_0000;
                mag = 64'($urandom_range(0, 32'(bound)));
            end
        endcase
        return $urandom_range(0, 1) ? -mag[31:0] : mag[31:0];
    endfunction

    // keeps the table ascending around the entry being rewritten
    function automatic logic [plsm_pkg::BP_W-1:0] fitting_breakpoint(int idx);
        logic [plsm_pkg::BP_W-1:0] lo;
        logic [plsm_pkg::BP_W-1:0] hi;
        lo = (idx == 0) ? '0 : bp_tab[idx-1];
        hi = (idx == TABLE_DEPTH-1) ? '1 : bp_tab[idx+1];
        if (hi < lo)
            return bp_tab[idx];
        return plsm_pkg::BP_W'($urandom_range(32'(hi), 32'(lo)));
    endfunction

    function automatic logic [plsm_pkg::SEG_W-1:0] pick_segment_count();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd31;
            2: return 5'd16;
            3: return 5'd1;
            4: return plsm_pkg::SEG_W'($urandom_range(17, 31));
            default: return plsm_pkg::SEG_W'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic flag_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic drive_item(input logic item_kind,
                              input logic [plsm_pkg::IN_IDX_W-1:0] idx,
                              input logic [plsm_pkg::BP_W-1:0] bp,
                              input logic signed [plsm_pkg::MOD_W-1:0] m,
                              input logic signed [plsm_pkg::STRAIN_W-1:0] s);
        @(negedge clk);
        start             = 1'b1;
        kind              = item_kind;
        entry_index       = idx;
        breakpoint_strain = bp;
        segment_modulus   = m;
        strain            = s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (item_kind == plsm_pkg::KIND_LOAD)
        begin
            bp_tab[idx]      = bp;
            modulus_tab[idx] = m;
            loads_sent++;
        end
        else
        begin
            pending_secants.push_back(predict_secant(s));
            queries_sent++;
        end
    endtask

    task automatic hold_off(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start             = 1'b0;
            kind              = 1'($urandom);
            entry_index       = plsm_pkg::IN_IDX_W'($urandom);
            breakpoint_strain = plsm_pkg::BP_W'($urandom);
            segment_modulus   = plsm_pkg::MOD_W'({$urandom, $urandom});
            strain            = $urandom;
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_secants.size() != 0)
            @(posedge clk);
        repeat (LOAD_SETTLE)
            @(posedge clk);
    endtask

    task automatic set_segment_count(logic [plsm_pkg::SEG_W-1:0] value);
        wait_for_results();
        @(negedge clk);
        segments_in_use_we = 1'b1;
        segments_in_use    = value;
        @(negedge clk);
        segments_in_use_we = 1'b0;
        segments_in_use    = plsm_pkg::SEG_W'($urandom);
        seg_count          = value;
        settings_used++;
    endtask

    task automatic load_sorted_table(bit back_to_back);
        longint unsigned next_bp;
        longint unsigned span;
        span    = ($urandom_range(0, 2) == 0) ? 64'h7FFF_FFFF : (64'h1 << $urandom_range(8, 30));
        next_bp = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(1, 32'(span / 16))) : 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (next_bp > 64'h7FFF_FFFF)
                next_bp = 64'h7FFF_FFFF;
            drive_item(plsm_pkg::KIND_LOAD, i[plsm_pkg::IN_IDX_W-1:0],
                       next_bp[plsm_pkg::BP_W-1:0], pick_modulus(), $urandom);
            hold_off(next_gap(back_to_back));
            // an occasional zero-length segment
            next_bp += ($urandom_range(0, 9) == 0) ? 0
                                                   : 64'($urandom_range(1, 32'(span / 15)));
        end
    endtask

    // only entry 0 is loaded here, so the count stays at its reset value of one
    task automatic test_single_entry();
        drive_item(plsm_pkg::KIND_LOAD, 4'd0, '0, plsm_pkg::LIMIT_POS, '0);
        drive_item(plsm_pkg::KIND_QUERY, '0, '0, '0, 32'sd0);
        drive_item(plsm_pkg::KIND_QUERY, '1, '1, '1, 32'sd1);
        drive_item(plsm_pkg::KIND_QUERY, '0, '0, '0, -32'sd1);
        drive_item(plsm_pkg::KIND_QUERY, '0, '0, '0, 32'sh7FFF_FFFF);
        drive_item(plsm_pkg::KIND_QUERY, '0, '0, '0, 32'sh8000_0000);
        // strain below the first breakpoint drives the quotient past the limit
        drive_item(plsm_pkg::KIND_LOAD, 4'd0, 31'h7FFF_FFFF, plsm_pkg::LIMIT_NEG, '1);
        drive_item(plsm_pkg::KIND_QUERY, '0, '0, '0, 32'sd1);
        drive_item(plsm_pkg::KIND_QUERY, '0, '0, '0, 32'sh8000_0000);
        drive_item(plsm_pkg::KIND_QUERY, '0, '0, '0, 32'sd0);
        drive_item(plsm_pkg::KIND_LOAD, 4'd0, 31'h7FFF_FFFF, plsm_pkg::LIMIT_POS, '0);
        drive_item(plsm_pkg::KIND_QUERY, '0, '0, '0, -32'sd1);
        wait_for_results();
    endtask

    task automatic test_segment_counts();
        logic [plsm_pkg::SEG_W-1:0] sweep [6];
        sweep = '{5'd16, 5'd0, 5'd31, 5'd17, 5'd1, 5'd8};
        load_sorted_table(1'b0);
        foreach (sweep[s])
        begin
            set_segment_count(sweep[s]);
            for (int j = 0; j < 20; j++)
            begin
                drive_item(plsm_pkg::KIND_QUERY, plsm_pkg::IN_IDX_W'($urandom),
                           plsm_pkg::BP_W'($urandom),
                           plsm_pkg::MOD_W'({$urandom, $urandom}), pick_strain());
                hold_off(next_gap(s % 2 == 0));
            end
        end
    endtask

    task automatic test_random_traffic();
        bit          back_to_back;
        int          idx;
        logic [31:0] bp_pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_segment_count(pick_segment_count());
            back_to_back = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                load_sorted_table(back_to_back);
            for (int j = 0; j < ITEMS_PER_PHASE; j++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    idx     = $urandom_range(0, TABLE_DEPTH-1);
                    bp_pick = ($urandom_range(0, 6) == 0) ? $urandom
                                                          : {1'b0, fitting_breakpoint(idx)};
                    drive_item(plsm_pkg::KIND_LOAD, idx[plsm_pkg::IN_IDX_W-1:0],
                               bp_pick[plsm_pkg::BP_W-1:0], pick_modulus(), $urandom);
                end
                else
                    drive_item(plsm_pkg::KIND_QUERY, plsm_pkg::IN_IDX_W'($urandom),
                               plsm_pkg::BP_W'($urandom),
                               plsm_pkg::MOD_W'({$urandom, $urandom}), pick_strain());
                if ($urandom_range(0, 59) == 0)
                    wait_for_results();
                else
                    hold_off(next_gap(back_to_back));
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        secant_t want;
        if (rst_n && done)
        begin
            if (pending_secants.size() == 0)
                flag_mismatch($sformatf("unexpected beat: modulus %0d saturated %0b",
                                        secant_modulus, saturated));
            else
            begin
                want = pending_secants.pop_front();
                results_checked++;
                if (saturated)
                    saturations_seen++;
                if (secant_modulus !== want.modulus)
                    flag_mismatch($sformatf("secant_modulus expected %0d got %0d",
                                            want.modulus, secant_modulus));
                if (saturated !== want.sat_flag)
                    flag_mismatch($sformatf("saturated expected %0b got %0b",
                                            want.sat_flag, saturated));
            end
        end
    end

    // ends the run if neither side moves a beat for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        start              = 1'b0;
        kind               = plsm_pkg::KIND_LOAD;
        entry_index        = '0;
        breakpoint_strain  = '0;
        segment_modulus    = '0;
        strain             = '0;
        segments_in_use_we = 1'b0;
        segments_in_use    = plsm_pkg::SEG_RESET;
        seg_count          = plsm_pkg::SEG_RESET;
        foreach (bp_tab[i])
        begin
            bp_tab[i]      = '0;
            modulus_tab[i] = '0;
        end
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_entry();
        test_segment_counts();
        test_random_traffic();

        wait_for_results();
        repeat (QUERY_LATENCY)
            @(posedge clk);

        $display("Sent %0d table loads and %0d queries across %0d segment-count settings.",
                 loads_sent, queries_sent, settings_used);
        $display("Checked %0d secant moduli, %0d of them clipped; %0d mismatches.",
                 results_checked, saturations_seen, mismatches);
        if (mismatches == 0 && pending_secants.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
